// ===== rtl/escc_pkg.sv =====
// Escape sequence codec: shared package.
// Types, constants and helper functions used by every rtl file of the codec.
// No dependencies.
package escc_pkg;

    localparam int MAX_PAIRS_DEF   = 8;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_LEN_W   = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_CHAR  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OCTAL_ENABLE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEX_ENABLE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_COUNT   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIRS_LOW    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIRS_HIGH   = 3'd6;

    // mode codes; anything else is plain copy
    localparam logic [1:0] MODE_DECODE = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;

    localparam logic [7:0] ESCAPE_RESET = 8'd92;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CTRL_LIMIT   = 8'd32;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_ESC,
        PH_OCT1,
        PH_OCT2,
        PH_HEX0,
        PH_HEX1
    } phase_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  escape_char;
        logic        octal_enable;
        logic        hex_enable;
        logic [3:0]  pair_count;
        logic [63:0] pairs_high;
        logic [63:0] pairs_low;
    } cfg_t;

    // up to four output bytes produced by one input byte
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            last;
    } bundle_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        hex_char = (d < 4'd10) ? (CHAR_ZERO + {4'b0, d}) : (8'h37 + {4'b0, d});
    endfunction

endpackage

// ===== rtl/escc_front.sv =====
// Escape sequence codec: front end.
// Classifies each accepted byte, runs the decode state and builds a bundle of results.
// Depends on escc_pkg.
module escc_front #(
    parameter int MAX_PAIRS = escc_pkg::MAX_PAIRS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  escc_pkg::cfg_t     cfg,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               accept,
    output escc_pkg::bundle_t  bundle,
    output logic               bundle_push
);
    import escc_pkg::*;

    phase_t     phase_reg, phase_next, phase_step;
    logic [7:0] pend_reg, pend_next;

    logic [7:0][15:0] pairs;
    logic       code_hit, val_hit;
    logic [7:0] code_val, val_code;
    logic       is_oct, is_x, hex_ok, is_esc;
    logic [2:0] oct_d;
    logic [3:0] hex_v;
    logic [3:0][7:0] data_v;
    logic [2:0] cnt_v;

    assign pairs = {cfg.pairs_high, cfg.pairs_low};

    // table search, lowest matching pair wins
    always_comb
    begin
        code_hit = 1'b0;
        code_val = 8'h00;
        val_hit  = 1'b0;
        val_code = 8'h00;
        for (int i = MAX_PAIRS - 1; i >= 0; i--)
        begin
            if (4'(i) < cfg.pair_count)
            begin
                if (pairs[3'(i)][15:8] == in_byte)
                begin
                    code_hit = 1'b1;
                    code_val = pairs[3'(i)][7:0];
                end
                if (pairs[3'(i)][7:0] == in_byte)
                begin
                    val_hit  = 1'b1;
                    val_code = pairs[3'(i)][15:8];
                end
            end
        end
    end

    always_comb
    begin
        is_oct = (in_byte[7:3] == 5'b00110);
        oct_d  = in_byte[2:0];
        is_x   = (in_byte == CHAR_LOWER_X) || (in_byte == CHAR_UPPER_X);
        is_esc = (in_byte == cfg.escape_char);
        hex_ok = 1'b1;
        hex_v  = 4'h0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_v = in_byte[3:0];
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
            hex_v = in_byte[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
    end

    // next decode phase and pending value
    always_comb
    begin
        phase_t plain_next;
        plain_next = is_esc ? PH_ESC : PH_NORMAL;
        phase_step = phase_reg;
        pend_next  = pend_reg;
        if (cfg.mode != MODE_DECODE)
        begin
            phase_step = PH_NORMAL;
            pend_next  = 8'h00;
        end
        else
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    if (cfg.octal_enable && is_oct)
                    begin
                        pend_next  = {5'b0, oct_d};
                        phase_step = PH_OCT1;
                    end
                    else if (cfg.hex_enable && is_x)
                        phase_step = PH_HEX0;
                    else if (code_hit)
                        phase_step = PH_NORMAL;
                    else
                        phase_step = plain_next;
                end
                PH_OCT1:
                begin
                    if (is_oct)
                    begin
                        pend_next  = {pend_reg[4:0], oct_d};
                        phase_step = PH_OCT2;
                    end
                    else
                        phase_step = plain_next;
                end
                PH_OCT2:
                    phase_step = is_oct ? PH_NORMAL : plain_next;
                PH_HEX0:
                begin
                    if (hex_ok)
                    begin
                        pend_next  = {4'b0, hex_v};
                        phase_step = PH_HEX1;
                    end
                    else
                        phase_step = plain_next;
                end
                PH_HEX1:
                    phase_step = hex_ok ? PH_NORMAL : plain_next;
                default:
                    phase_step = plain_next;
            endcase
        end
        phase_next = in_last ? PH_NORMAL : phase_step;
    end

    // result bytes of this input
    always_comb
    begin
        logic       first_en, plain_en;
        logic [7:0] first_val;
        first_en  = 1'b0;
        first_val = 8'h00;
        plain_en  = 1'b0;
        data_v    = '0;
        cnt_v     = 3'd0;
        case (cfg.mode)
            MODE_DECODE:
            begin
                case (phase_reg)
                    PH_ESC:
                    begin
                        if (!(cfg.octal_enable && is_oct) && !(cfg.hex_enable && is_x))
                        begin
                            first_en  = code_hit;
                            first_val = code_val;
                            plain_en  = !code_hit;
                        end
                    end
                    PH_OCT1:
                    begin
                        first_en  = !is_oct;
                        first_val = pend_reg;
                        plain_en  = !is_oct;
                    end
                    PH_OCT2:
                    begin
                        first_en  = 1'b1;
                        first_val = is_oct ? {pend_reg[4:0], oct_d} : pend_reg;
                        plain_en  = !is_oct;
                    end
                    PH_HEX0:
                        plain_en = !hex_ok;
                    PH_HEX1:
                    begin
                        first_en  = 1'b1;
                        first_val = hex_ok ? {pend_reg[3:0], hex_v} : pend_reg;
                        plain_en  = !hex_ok;
                    end
                    default:
                        plain_en = 1'b1;
                endcase
                if (first_en)
                begin
                    data_v[cnt_v[1:0]] = first_val;
                    cnt_v = cnt_v + 3'd1;
                end
                if (plain_en && !is_esc)
                begin
                    data_v[cnt_v[1:0]] = in_byte;
                    cnt_v = cnt_v + 3'd1;
                end
                // digits still collected at end of string are flushed
                if (in_last && (phase_step == PH_OCT1 || phase_step == PH_OCT2 ||
                                phase_step == PH_HEX1))
                begin
                    data_v[cnt_v[1:0]] = pend_next;
                    cnt_v = cnt_v + 3'd1;
                end
            end
            MODE_ENCODE:
            begin
                if (val_hit)
                begin
                    data_v[0] = cfg.escape_char;
                    data_v[1] = val_code;
                    cnt_v     = 3'd2;
                end
                else if ((cfg.octal_enable || cfg.hex_enable) && in_byte < CTRL_LIMIT)
                begin
                    data_v[0] = cfg.escape_char;
                    cnt_v     = 3'd4;
                    if (cfg.hex_enable)
                    begin
                        data_v[1] = CHAR_LOWER_X;
                        data_v[2] = hex_char(in_byte[7:4]);
                        data_v[3] = hex_char(in_byte[3:0]);
                    end
                    else
                    begin
                        data_v[1] = CHAR_ZERO + {6'b0, in_byte[7:6]};
                        data_v[2] = CHAR_ZERO + {5'b0, in_byte[5:3]};
                        data_v[3] = CHAR_ZERO + {5'b0, in_byte[2:0]};
                    end
                end
                else
                begin
                    data_v[0] = in_byte;
                    cnt_v     = 3'd1;
                end
            end
            default:
            begin
                data_v[0] = in_byte;
                cnt_v     = 3'd1;
            end
        endcase
    end

    assign bundle.data  = data_v;
    assign bundle.count = cnt_v;
    assign bundle.last  = in_last;
    // an empty bundle is queued only to carry a bare end marker
    assign bundle_push  = accept && ((cnt_v != 3'd0) || in_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            pend_reg  <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

// ===== rtl/escc_queue.sv =====
// Escape sequence codec: bundle queue between front and back end.
// Small register FIFO with a combinational head read.
// Depends on escc_pkg.
module escc_queue #(
    parameter int DEPTH = escc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  escc_pkg::bundle_t  wr_data,
    input  logic               rd_en,
    output escc_pkg::bundle_t  rd_data,
    output logic               is_empty,
    output logic               is_full
);
    import escc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t       slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_wr, do_rd;

    assign is_empty = (fill_reg == CW'(0));
    assign is_full  = (fill_reg == CW'(DEPTH));
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            fill_next = fill_reg + CW'(1);
        else if (do_rd && !do_wr)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/escc_back.sv =====
// Escape sequence codec: back end.
// Serializes queued bundles one byte per transfer, keeps the string length count
// and holds the result register. Depends on escc_pkg.
module escc_back #(
    parameter int LENGTH_BITS = escc_pkg::LENGTH_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  escc_pkg::bundle_t              head,
    input  logic                           head_valid,
    output logic                           head_done,
    output logic [7:0]                     out_byte,
    output logic                           byte_valid,
    output logic                           run_last,
    output logic                           string_end,
    output logic [escc_pkg::OUT_LEN_W-1:0] out_length,
    output logic                           empty,
    input  logic                           pop
);
    import escc_pkg::*;

    logic                   ovalid_reg, ovalid_next;
    logic [1:0]             idx_reg, idx_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next, cnt_inc, cnt_shown;
    logic [31:0]            len_wide;
    logic [7:0]             byte_reg;
    logic                   bvalid_reg, rlast_reg, send_reg;
    logic [OUT_LEN_W-1:0]   len_reg;
    logic                   load, is_bare, is_final;

    assign load     = head_valid && (!ovalid_reg || pop);
    assign is_bare  = (head.count == 3'd0);
    assign is_final = is_bare || (({1'b0, idx_reg} + 3'd1) == head.count);
    assign cnt_inc  = (cnt_reg == {LENGTH_BITS{1'b1}}) ? cnt_reg : cnt_reg + LENGTH_BITS'(1);
    assign cnt_shown = is_bare ? cnt_reg : cnt_inc;
    assign len_wide = 32'(cnt_shown);
    assign head_done = load && is_final;

    always_comb
    begin
        ovalid_next = ovalid_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        if (load)
        begin
            ovalid_next = 1'b1;
            idx_next    = is_final ? 2'd0 : idx_reg + 2'd1;
            cnt_next    = (is_final && head.last) ? '0 : cnt_shown;
        end
        else if (pop)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            idx_reg    <= 2'd0;
            cnt_reg    <= '0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            idx_reg    <= idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= is_bare ? 8'h00 : head.data[idx_reg];
            bvalid_reg <= !is_bare;
            rlast_reg  <= is_final;
            send_reg   <= is_final && head.last;
            len_reg    <= len_wide[OUT_LEN_W-1:0];
        end
    end

    assign empty      = !ovalid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign run_last   = rlast_reg;
    assign string_end = send_reg;
    assign out_length = len_reg;

endmodule

// ===== rtl/escc_core_top_placeholder.sv =====
// Escape sequence codec: configuration register file.
// Holds the seven configuration registers written through the plain write port.
// Depends on escc_pkg.
module escc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [escc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [escc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output escc_pkg::cfg_t                   cfg
);
    import escc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:         cfg_next.mode         = cfg_data[1:0];
                REG_ESCAPE_CHAR:  cfg_next.escape_char  = cfg_data[7:0];
                REG_OCTAL_ENABLE: cfg_next.octal_enable = cfg_data[0];
                REG_HEX_ENABLE:   cfg_next.hex_enable   = cfg_data[0];
                REG_PAIR_COUNT:   cfg_next.pair_count   = cfg_data[3:0];
                REG_PAIRS_LOW:    cfg_next.pairs_low    = cfg_data;
                REG_PAIRS_HIGH:   cfg_next.pairs_high   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{mode: MODE_DECODE, escape_char: ESCAPE_RESET,
                         octal_enable: 1'b0, hex_enable: 1'b0, pair_count: 4'd0,
                         pairs_high: 64'd0, pairs_low: 64'd0};
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/escape_sequence_codec_core.sv =====
// escape_sequence_codec_core: C-style escape sequence encoder / decoder.
//
// Input channel (push/full): one source byte per transfer, in_last on the
// final byte of a string. A byte is taken at a clock edge with push high and
// full low; while the bundle queue has room, a byte can be taken every cycle.
// Result channel (empty/pop): queue-like; the oldest result sits on the
// result ports while empty is low and leaves on a clock edge with pop high.
// Each input byte yields zero to four results (a control byte encoded as an
// octal or hex escape gives four), plus a bare end marker (byte_valid low)
// when a string ends with nothing emitted. run_last marks the last result of
// one input byte, string_end the last result of the string, and out_length
// counts bytes of the current string, saturating at 2^LENGTH_BITS-1.
// A taken byte's bundle is queued at the taking edge; the result register
// loads from the queue head once it is free. Results leave at one per cycle
// while pop is held high, so the result serializer sets throughput: each
// result and each bare end marker takes its own turn in the back end, a byte
// with no result none; a QUEUE_DEPTH bundle queue absorbs bursts. When the
// receiver stalls the queue fills and full rises; nothing is lost.
// Reset clears the decode state, the queue, the length count and the
// configuration (decode mode, backslash escape character, empty table).
// Configuration is written through cfg_we/cfg_index/cfg_data by the user,
// only while the block is idle; the block itself does not enforce this.
module escape_sequence_codec_core #(
    parameter int MAX_PAIRS   = escc_pkg::MAX_PAIRS_DEF,
    parameter int LENGTH_BITS = escc_pkg::LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = escc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       in_byte,
    input  logic                             in_last,
    // result channel
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       out_byte,
    output logic                             byte_valid,
    output logic                             run_last,
    output logic                             string_end,
    output logic [escc_pkg::OUT_LEN_W-1:0]   out_length,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [escc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [escc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import escc_pkg::*;

    cfg_t    cfg;
    bundle_t front_bundle, head_bundle;
    logic    front_push, accept;
    logic    q_empty, q_full, head_done;

    // an input transfer happens whenever push is high and the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    escc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // front: decode state machine / encoder, at most one bundle per input byte
    escc_front #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .accept      (accept),
        .bundle      (front_bundle),
        .bundle_push (front_push)
    );

    // decouples classification from serialization
    escc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_bundle),
        .rd_en    (head_done),
        .rd_data  (head_bundle),
        .is_empty (q_empty),
        .is_full  (q_full)
    );

    // back: one result per transfer, length count, result register
    escc_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_bundle),
        .head_valid (!q_empty),
        .head_done  (head_done),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end),
        .out_length (out_length),
        .empty      (empty),
        .pop        (pop)
    );

`ifndef SYNTHESIS
    // the end of a string always closes the run of its input byte
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && string_end |-> run_last)
        else $error("string_end without run_last");

    // a bare marker only appears as the sole result of a final byte
    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !byte_valid |-> string_end && run_last && out_byte == 8'h00)
        else $error("bare marker not at string end");

    // after a string ends, the next data byte starts the count over
    a_count_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !empty && string_end |=> empty || !byte_valid || out_length == 16'd1)
        else $error("length count did not restart");
`endif

endmodule
